>>> sv/pert_pkg.sv
// shared types and constants of the priority event rule table
`timescale 1ns / 1ps
package pert_pkg;
	localparam int MAX_RULES = 16;
	localparam int MAX_ACTIONS = 4;
	localparam int OUT_LIMIT = 64;
	localparam int IDX_W = $clog2(MAX_RULES);
	localparam int TOT_W = $clog2(MAX_RULES + 1);
	localparam int ACT_W = $clog2(MAX_ACTIONS);
	localparam int OUT_W = $clog2(OUT_LIMIT + 1);

	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_ENABLE = 3'd3;
	localparam logic [2:0] OP_FIRE = 3'd4;
	localparam logic [2:0] OP_EVAL = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] rule_index;
		logic [3:0] trigger_code;
		logic [19:0] limit_mm;
		logic [7:0] rule_priority;
		logic enable_flag;
		logic [2:0] act_num;
		logic [31:0] actions;
		logic [19:0] range_mm;
	} item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input word
		logic scan_clr;  // restart scan pointer and best tracking
		logic scan_step; // examine rule at scan pointer
		logic shift;     // move rule at ptr+1 down to ptr
		logic append;    // write new rule at end
		logic set_en;    // write enable of addressed rule
		logic dec;       // drop rule count by one
		logic clear;     // empty table
		logic emit_load; // start emission of rule at emit index
		logic emit_step; // one action taken into the holding register
		logic disarm;    // disable rule at scan pointer
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic full;
		logic idx_bad;
		logic scan_done;
		logic shift_done;
		logic hit;         // eval: rule at pointer qualifies
		logic found;       // fire: a winner exists
		logic act_left;    // actions remain in the current rule
		logic out_full;    // emission limit reached
		logic any_out;     // holding register carries an action
	} stat_t;
endpackage

>>> sv/pert_datapath.sv
// rule storage, scan pointer, best tracking and action emission
`timescale 1ns / 1ps
module pert_datapath (
	input  logic clk,
	input  logic arst_n,
	input  pert_pkg::item_t item,
	input  logic [3:0] dist_code,
	input  pert_pkg::cmd_t cmd,
	output pert_pkg::stat_t stat,
	output logic [7:0] action_code,
	output logic [4:0] rules_in_use
);
	import pert_pkg::*;

	logic [3:0] trig_q [MAX_RULES];
	logic [19:0] thr_q [MAX_RULES];
	logic [7:0] prio_q [MAX_RULES];
	logic en_q [MAX_RULES];
	logic [2:0] cnt_q [MAX_RULES];
	logic [31:0] act_q [MAX_RULES];
	logic [TOT_W-1:0] total_q;
	item_t it_q;
	logic [TOT_W-1:0] ptr_q;
	logic [7:0] top_prio_q;
	logic [IDX_W-1:0] best_q;
	logic found_q;
	logic [IDX_W-1:0] emit_idx_q;
	logic [2:0] act_pos_q;
	logic [2:0] act_cnt_q;
	logic [OUT_W-1:0] nout_q;
	logic [7:0] held_q;
	logic held_v_q;

	logic [IDX_W-1:0] pidx, pnext;
	logic [2:0] cnt_sat;
	logic match_trig, match_dist;
	logic [7:0] cur_act;

	assign pidx = ptr_q[IDX_W-1:0];
	assign pnext = pidx + 1'b1;
	assign cnt_sat = (it_q.act_num > 3'(MAX_ACTIONS)) ? 3'(MAX_ACTIONS)
		: it_q.act_num;
	assign match_trig = en_q[pidx] && trig_q[pidx] == it_q.trigger_code
		&& prio_q[pidx] > top_prio_q;
	assign match_dist = en_q[pidx] && trig_q[pidx] == dist_code
		&& it_q.range_mm <= thr_q[pidx];
	assign cur_act = act_q[emit_idx_q][8*act_pos_q[ACT_W-1:0] +: 8];

	// status toward the controller
	always_comb begin
		stat.op = it_q.op;
		stat.full = total_q >= TOT_W'(MAX_RULES);
		stat.idx_bad = {1'b0, it_q.rule_index} >= 5'(total_q);
		stat.scan_done = ptr_q >= total_q;
		stat.shift_done = (5'(ptr_q) + 5'd1) >= 5'(total_q);
		stat.hit = match_dist;
		stat.found = found_q;
		stat.act_left = act_pos_q < act_cnt_q;
		stat.out_full = nout_q >= OUT_W'(OUT_LIMIT);
		stat.any_out = held_v_q;
	end

	assign action_code = held_q;
	assign rules_in_use = 5'(total_q);

	// rule storage
	always_ff @(posedge clk) begin
		if (cmd.load) it_q <= item;
		if (cmd.append) begin
			trig_q[total_q[IDX_W-1:0]] <= it_q.trigger_code;
			thr_q[total_q[IDX_W-1:0]] <= it_q.limit_mm;
			prio_q[total_q[IDX_W-1:0]] <= it_q.rule_priority;
			en_q[total_q[IDX_W-1:0]] <= it_q.enable_flag;
			cnt_q[total_q[IDX_W-1:0]] <= cnt_sat;
			act_q[total_q[IDX_W-1:0]] <= it_q.actions;
		end
		if (cmd.shift) begin
			trig_q[pidx] <= trig_q[pnext];
			thr_q[pidx] <= thr_q[pnext];
			prio_q[pidx] <= prio_q[pnext];
			en_q[pidx] <= en_q[pnext];
			cnt_q[pidx] <= cnt_q[pnext];
			act_q[pidx] <= act_q[pnext];
		end
		if (cmd.set_en) en_q[it_q.rule_index[IDX_W-1:0]] <= it_q.enable_flag;
		if (cmd.disarm) en_q[pidx] <= 1'b0;
	end

	// count, pointer, best and emission registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ptr_q <= '0;
			top_prio_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			emit_idx_q <= '0;
			act_pos_q <= '0;
			act_cnt_q <= '0;
			nout_q <= '0;
			held_q <= '0;
			held_v_q <= 1'b0;
		end else begin
			if (cmd.clear) total_q <= '0;
			if (cmd.append) total_q <= total_q + 1'b1;
			if (cmd.dec) total_q <= total_q - 1'b1;
			if (cmd.load) begin
				nout_q <= '0;
				held_v_q <= 1'b0;
			end
			if (cmd.scan_clr) begin
				ptr_q <= (it_q.op == OP_REMOVE) ? TOT_W'(it_q.rule_index) : '0;
				top_prio_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (match_trig && it_q.op == OP_FIRE) begin
					top_prio_q <= prio_q[pidx];
					best_q <= pidx;
					found_q <= 1'b1;
				end
			end
			if (cmd.scan_step || cmd.shift) ptr_q <= ptr_q + 1'b1;
			if (cmd.emit_load) begin
				emit_idx_q <= (it_q.op == OP_FIRE) ? best_q : pidx;
				act_pos_q <= '0;
				act_cnt_q <= (it_q.op == OP_FIRE) ? cnt_q[best_q] : cnt_q[pidx];
			end
			// next action goes into the holding register
			if (cmd.emit_step) begin
				act_pos_q <= act_pos_q + 1'b1;
				nout_q <= nout_q + 1'b1;
				held_q <= cur_act;
				held_v_q <= 1'b1;
			end
		end
	end
endmodule

>>> sv/pert_ctrl.sv
// sequencer of table operations and result handshake
`timescale 1ns / 1ps
module pert_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic out_has,
	output logic out_last,
	output logic [1:0] out_status,
	input  pert_pkg::stat_t stat,
	output pert_pkg::cmd_t cmd
);
	import pert_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SCAN, S_SHIFT, S_EMIT, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] status_q;
	logic out_pend;

	assign in_ready = state_q == S_IDLE;
	assign out_status = (state_q == S_DONE) ? status_q : ST_OK;
	// a new action is ready; the held one goes out first when there is one
	assign out_pend = state_q == S_EMIT && stat.act_left && !stat.out_full;
	assign out_valid = (out_pend && stat.any_out) || state_q == S_DONE;
	assign out_has = stat.any_out && (state_q == S_EMIT || state_q == S_DONE);
	// the held action flushed at the end is the last word of the item
	assign out_last = state_q == S_DONE;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = in_valid && state_q == S_IDLE;
		case (state_q)
			S_DECODE: begin
				cmd.scan_clr = 1'b1;
				case (stat.op)
					OP_CLEAR: cmd.clear = 1'b1;
					OP_ADD: cmd.append = !stat.full;
					OP_ENABLE: cmd.set_en = !stat.idx_bad;
					default: ;
				endcase
			end
			S_SCAN: begin
				if (!stat.scan_done) begin
					cmd.scan_step = 1'b1;
					if (stat.op == OP_EVAL && stat.hit) begin
						cmd.disarm = 1'b1;
						cmd.emit_load = 1'b1;
						cmd.scan_step = 1'b0;
					end
				end else if (stat.op == OP_FIRE && stat.found) begin
					cmd.emit_load = 1'b1;
				end
			end
			S_SHIFT: begin
				if (stat.shift_done) cmd.dec = 1'b1;
				else cmd.shift = 1'b1;
			end
			S_EMIT: cmd.emit_step = out_pend && (!stat.any_out || out_ready);
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECODE;
				S_DECODE: begin
					status_q <= ST_OK;
					case (stat.op)
						OP_ADD: begin
							if (stat.full) status_q <= ST_FULL;
							state_q <= S_DONE;
						end
						OP_REMOVE: begin
							if (stat.idx_bad) begin
								status_q <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end else state_q <= S_SHIFT;
						end
						OP_ENABLE: begin
							if (stat.idx_bad) status_q <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end
						OP_FIRE, OP_EVAL: state_q <= S_SCAN;
						default: state_q <= S_DONE;
					endcase
				end
				S_SCAN: begin
					if (cmd.emit_load) state_q <= S_EMIT;
					else if (stat.scan_done) state_q <= S_DONE;
				end
				S_SHIFT: if (stat.shift_done) state_q <= S_DONE;
				S_EMIT: begin
					if (!(stat.act_left && !stat.out_full)) begin
						// fire ends after its rule; eval resumes the scan at this rule, now disarmed
						state_q <= (stat.op == OP_FIRE) ? S_DONE : S_SCAN;
					end
				end
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/priority_event_rule_table.sv
// top level of the priority event rule table
`timescale 1ns / 1ps
// Ordered table of up to 16 event rules driven by op words on the input stream.
// Clear, add, remove and set enable return one word (has_action 0, last 1,
// status and rule count). Fire and evaluate return one word per emitted action
// with last on the final one, or a single word with has_action 0 when nothing
// is emitted; each action waits in a holding register until the next one is
// known, so last is set on the right word. Remove moves each later rule down
// by one place and then drops the count; fire and evaluate scan the table at
// one rule per cycle, and an evaluate scan pauses while a matching rule emits
// its actions. The next word is accepted only after the last result word
// of the current one has been taken.
module priority_event_rule_table (
	input  logic clk,
	input  logic arst_n,
	// tdata: op[2:0] rule_index[6:3] trigger_code[10:7] limit_mm[30:11]
	// rule_priority[38:31] enable_flag[39] act_num[42:40] action_a[50:43]
	// action_b[58:51] action_c[66:59] action_d[74:67] range_mm[94:75]
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [95:0] s_tdata,
	// tdata: status[1:0] action_code[9:2] rules_in_use[14:10]; tuser: has_action
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,
	output logic m_tuser,
	output logic m_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [0:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pert_pkg::*;

	item_t item;
	cmd_t cmd;
	stat_t stat;
	logic [3:0] dist_code_q;
	logic [7:0] code;
	logic [4:0] total;
	logic has, lst;
	logic [1:0] status;

	assign item.op = s_tdata[2:0];
	assign item.rule_index = s_tdata[6:3];
	assign item.trigger_code = s_tdata[10:7];
	assign item.limit_mm = s_tdata[30:11];
	assign item.rule_priority = s_tdata[38:31];
	assign item.enable_flag = s_tdata[39];
	assign item.act_num = s_tdata[42:40];
	assign item.actions = s_tdata[74:43];
	assign item.range_mm = s_tdata[94:75];

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {28'd0, dist_code_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dist_code_q <= 4'd3;
		else if (psel && penable && pwrite && paddr == 1'b0) dist_code_q <= pwdata[3:0];
	end

	pert_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_has(has), .out_last(lst),
		.out_status(status), .stat(stat), .cmd(cmd)
	);

	pert_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .dist_code(dist_code_q),
		.cmd(cmd), .stat(stat), .action_code(code), .rules_in_use(total)
	);

	assign m_tuser = has;
	assign m_tlast = lst;
	assign m_tdata = {1'b0, total, has ? code : 8'd0, status};
endmodule

>>> sim/tb_priority_event_rule_table.sv
// testbench for the priority event rule table: directed table plus random ops, scoreboard check
`timescale 1ns / 1ps
module tb_priority_event_rule_table;
	import pert_pkg::*;

	typedef struct packed {
		logic [1:0] st;
		logic has;
		logic [7:0] code;
		logic lst;
		logic [4:0] tot;
	} word_t;

	typedef struct {
		item_t it;
		bit typed;
		logic [1:0] st;
		logic [4:0] tot;
	} row_t;

	localparam int DRAIN = 100;
	localparam int WD_LIMIT = 3000;
	localparam logic [2:0] OP_IDLE6 = 3'd6;
	localparam logic [2:0] OP_IDLE7 = 3'd7;

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [95:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser, m_tlast;
	logic [15:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [0:0] paddr;
	logic [31:0] pwdata, prdata;

	priority_event_rule_table DUT (.*);

	// shadow copy of the rule table
	logic [3:0] tbl_trig [MAX_RULES];
	logic [19:0] tbl_thr [MAX_RULES];
	logic [7:0] tbl_prio [MAX_RULES];
	logic tbl_en [MAX_RULES];
	logic [2:0] tbl_cnt [MAX_RULES];
	logic [31:0] tbl_acts [MAX_RULES];
	int tbl_total = 0;
	logic [3:0] dist_code = 4'd3;

	word_t pending_words[$];
	row_t dir_rows[$];
	int fails = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	int burst_left = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic item_t mk(logic [2:0] op, logic [3:0] idx, logic [3:0] trig,
			logic [19:0] thr, logic [7:0] prio, logic en, logic [2:0] cnt,
			logic [31:0] acts, logic [19:0] rng);
		item_t it;
		it.op = op; it.rule_index = idx; it.trigger_code = trig;
		it.limit_mm = thr; it.rule_priority = prio; it.enable_flag = en;
		it.act_num = cnt; it.actions = acts; it.range_mm = rng;
		return it;
	endfunction

	function automatic logic [95:0] pack_word(item_t it);
		return {1'b0, it.range_mm, it.actions, it.act_num, it.enable_flag,
			it.rule_priority, it.limit_mm, it.trigger_code, it.rule_index, it.op};
	endfunction

	// split an input word into its fields, first field in the lowest bits
	function automatic item_t unpack_word(logic [95:0] d);
		item_t it;
		it.op = d[2:0]; it.rule_index = d[6:3]; it.trigger_code = d[10:7];
		it.limit_mm = d[30:11]; it.rule_priority = d[38:31]; it.enable_flag = d[39];
		it.act_num = d[42:40]; it.actions = d[74:43]; it.range_mm = d[94:75];
		return it;
	endfunction

	// queue the action words of one rule, capped at the output limit
	function automatic void emit_rule_actions(int idx, ref int n);
		for (int a = 0; a < tbl_cnt[idx]; a++) begin
			if (n >= OUT_LIMIT)
				break;
			pending_words.push_back({ST_OK, 1'b1, tbl_acts[idx][8*a +: 8], 1'b0,
				5'(tbl_total)});
			n++;
		end
	endfunction

	// apply one op to the shadow table and queue the words it produces
	function automatic void predict_words(item_t it);
		int n;
		logic [1:0] st;
		int best;
		logic [7:0] top_prio;
		word_t w;
		n = 0;
		st = ST_OK;
		case (it.op)
			OP_CLEAR: tbl_total = 0;
			OP_ADD: begin
				if (tbl_total >= MAX_RULES) begin
					st = ST_FULL;
				end else begin
					tbl_trig[tbl_total] = it.trigger_code;
					tbl_thr[tbl_total] = it.limit_mm;
					tbl_prio[tbl_total] = it.rule_priority;
					tbl_en[tbl_total] = it.enable_flag;
					tbl_cnt[tbl_total] = it.act_num > MAX_ACTIONS ? 3'(MAX_ACTIONS)
						: it.act_num;
					tbl_acts[tbl_total] = it.actions;
					tbl_total++;
				end
			end
			OP_REMOVE: begin
				if (it.rule_index >= tbl_total) begin
					st = ST_NOT_FOUND;
				end else begin
					for (int i = it.rule_index; i + 1 < tbl_total; i++) begin
						tbl_trig[i] = tbl_trig[i+1]; tbl_thr[i] = tbl_thr[i+1];
						tbl_prio[i] = tbl_prio[i+1]; tbl_en[i] = tbl_en[i+1];
						tbl_cnt[i] = tbl_cnt[i+1]; tbl_acts[i] = tbl_acts[i+1];
					end
					tbl_total--;
				end
			end
			OP_ENABLE: begin
				if (it.rule_index >= tbl_total)
					st = ST_NOT_FOUND;
				else
					tbl_en[it.rule_index] = it.enable_flag;
			end
			OP_FIRE: begin
				best = -1;
				top_prio = 0;
				for (int i = 0; i < tbl_total; i++) begin
					if (tbl_en[i] && tbl_trig[i] == it.trigger_code &&
							tbl_prio[i] > top_prio) begin
						top_prio = tbl_prio[i];
						best = i;
					end
				end
				if (best >= 0)
					emit_rule_actions(best, n);
			end
			OP_EVAL: begin
				for (int i = 0; i < tbl_total; i++) begin
					if (tbl_en[i] && tbl_trig[i] == dist_code &&
							it.range_mm <= tbl_thr[i]) begin
						emit_rule_actions(i, n);
						tbl_en[i] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (n == 0) begin
			pending_words.push_back({st, 1'b0, 8'd0, 1'b1, 5'(tbl_total)});
		end else begin
			w = pending_words.pop_back();
			w.lst = 1'b1;
			pending_words.push_back(w);
		end
	endfunction

	task automatic report(string what, word_t got, word_t want);
		$display({"mismatch %s: got st=%0d has=%0b code=%0d last=%0b tot=%0d,",
			" want st=%0d has=%0b code=%0d last=%0b tot=%0d"},
			what, got.st, got.has, got.code, got.lst, got.tot,
			want.st, want.has, want.code, want.lst, want.tot);
		fails++;
	endtask

	// input monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			predict_words(unpack_word(s_tdata));
	end

	// output word check
	always @(posedge clk) begin
		word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[1:0], m_tuser, m_tdata[9:2], m_tlast, m_tdata[14:10]};
			if (pending_words.size() == 0)
				report("unexpected word", got, '0);
			else if (got !== pending_words[0])
				report("word", got, pending_words.pop_front());
			else
				void'(pending_words.pop_front());
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: long hold-off on request, else a shifting stall pattern
	initial begin
		int mode;
		int cyc;
		m_tready = 0;
		mode = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (mode == 0) begin
				m_tready <= 1'b1;
			end else if (mode == 1) begin
				m_tready <= 1'($urandom_range(0, 1));
			end else begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// offer one word, with bursts and gaps between them
	task automatic send_word(item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata <= pack_word(it);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	// let the block go quiet before touching its register
	task automatic drain_out();
		s_tvalid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_dist_code(logic [3:0] val);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {28'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		dist_code = val;
		@(negedge clk);
	endtask

	function automatic item_t rand_item();
		item_t it;
		int pick;
		logic [3:0] trig_set [3];
		trig_set[0] = dist_code; trig_set[1] = 4'd1; trig_set[2] = 4'd2;
		it = mk(3'd0, 4'($urandom), 4'($urandom), 20'($urandom), 8'($urandom),
			1'($urandom), 3'($urandom), $urandom, 20'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 32) it.op = OP_ADD;
		else if (pick < 55) it.op = OP_FIRE;
		else if (pick < 73) it.op = OP_EVAL;
		else if (pick < 84) it.op = OP_ENABLE;
		else if (pick < 95) it.op = OP_REMOVE;
		else if (pick < 97) it.op = OP_CLEAR;
		else it.op = $urandom_range(0, 1) ? OP_IDLE6 : OP_IDLE7;
		if ($urandom_range(0, 9) < 7)
			it.trigger_code = trig_set[$urandom_range(0, 2)];
		if ($urandom_range(0, 9) < 7 && tbl_total > 0)
			it.rule_index = 4'($urandom_range(0, tbl_total - 1));
		if ($urandom_range(0, 3) == 0)
			it.limit_mm = 20'hFFFFF;
		if ($urandom_range(0, 2) == 0)
			it.range_mm = 20'($urandom_range(0, 4000));
		if ($urandom_range(0, 9) == 0)
			it.rule_priority = 8'd0;
		if ($urandom_range(0, 3) != 0)
			it.enable_flag = 1'b1;
		return it;
	endfunction

	initial begin
		item_t it;
		word_t w;
		logic [3:0] cfg_vals [5];
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;

		// directed rows; typed expectations only on single-word results
		dir_rows.push_back('{mk(OP_REMOVE, 4'd0, 0, 0, 0, 0, 0, 0, 0), 1, ST_NOT_FOUND, 5'd0});
		dir_rows.push_back('{mk(OP_ENABLE, 4'd15, 0, 0, 0, 1, 0, 0, 0), 1, ST_NOT_FOUND, 5'd0});
		dir_rows.push_back('{mk(OP_FIRE, 0, 4'd3, 0, 0, 0, 0, 0, 0), 1, ST_OK, 5'd0});
		dir_rows.push_back('{mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 20'd0), 1, ST_OK, 5'd0});
		dir_rows.push_back('{mk(OP_IDLE6, 4'd15, 4'd15, 20'hFFFFF, 8'hFF, 1, 3'd7, '1, '1),
			1, ST_OK, 5'd0});
		dir_rows.push_back('{mk(OP_IDLE7, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 5'd0});
		dir_rows.push_back('{mk(OP_ADD, 0, 4'd3, 20'hFFFFF, 8'hFF, 1, 3'd4, 32'h04030201, 0),
			1, ST_OK, 5'd1});
		// distance rule with no actions
		dir_rows.push_back('{mk(OP_ADD, 0, 4'd3, 20'd0, 8'd1, 1, 3'd0, 32'hFFFFFFFF, 0),
			1, ST_OK, 5'd2});
		// zero priority, oversized action count
		dir_rows.push_back('{mk(OP_ADD, 0, 4'd5, 20'd7, 8'd0, 1, 3'd7, 32'hA4A3A2A1, 0),
			1, ST_OK, 5'd3});
		dir_rows.push_back('{mk(OP_ADD, 0, 4'd5, 20'd9, 8'd10, 1, 3'd2, 32'h00B2B1B0, 0),
			1, ST_OK, 5'd4});
		// priority tie, lower index must win
		dir_rows.push_back('{mk(OP_ADD, 0, 4'd5, 20'd9, 8'd10, 1, 3'd1, 32'h000000C0, 0),
			1, ST_OK, 5'd5});
		dir_rows.push_back('{mk(OP_FIRE, 0, 4'd5, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0});
		dir_rows.push_back('{mk(OP_FIRE, 0, 4'd3, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0});
		dir_rows.push_back('{mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 20'hFFFFF), 0, ST_OK, 0});
		dir_rows.push_back('{mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 20'd0), 0, ST_OK, 0});
		dir_rows.push_back('{mk(OP_ENABLE, 4'd1, 0, 0, 0, 1, 0, 0, 0), 1, ST_OK, 5'd5});
		dir_rows.push_back('{mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 20'd0), 0, ST_OK, 0});
		dir_rows.push_back('{mk(OP_REMOVE, 4'd0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 5'd4});
		dir_rows.push_back('{mk(OP_REMOVE, 4'd15, 0, 0, 0, 0, 0, 0, 0), 1, ST_NOT_FOUND, 5'd4});
		dir_rows.push_back('{mk(OP_FIRE, 0, 4'd5, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0});
		dir_rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 5'd0});

		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed walk; typed rows replace the predicted closing word
		foreach (dir_rows[r]) begin
			send_word(dir_rows[r].it);
			if (dir_rows[r].typed) begin
				w = pending_words.pop_back();
				pending_words.push_back({dir_rows[r].st, 1'b0, 8'd0, 1'b1, dir_rows[r].tot});
			end
		end

		cfg_vals[0] = 4'd15; cfg_vals[1] = 4'd0; cfg_vals[2] = 4'($urandom);
		cfg_vals[3] = 4'd3; cfg_vals[4] = 4'($urandom);
		for (int ph = 0; ph < 5; ph++) begin
			drain_out();
			write_dist_code(cfg_vals[ph]);
			if (ph == 2) begin
				// fill past capacity while the output is held off, then a maximal eval
				hold_left = 400;
				send_word(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
				for (int k = 0; k < MAX_RULES + 1; k++)
					send_word(mk(OP_ADD, 0, dist_code, 20'hFFFFF, 8'($urandom_range(1, 255)),
						1, 3'd4, $urandom, 0));
				send_word(mk(OP_FIRE, 0, dist_code, 0, 0, 0, 0, 0, 0));
				send_word(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 20'($urandom)));
			end
			for (int k = 0; k < 36; k++) begin
				it = rand_item();
				send_word(it);
			end
		end

		s_tvalid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (DRAIN) @(negedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

>>> filelist.f
sv/pert_pkg.sv
sv/pert_datapath.sv
sv/pert_ctrl.sv
sv/priority_event_rule_table.sv
sim/tb_priority_event_rule_table.sv
